FILE: hdl/scx_pkg.sv
// Shared types and constants for the moving-average crossover signal unit.
// No dependencies; compile first.
package scx_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_BITS_DEF = 32;

  localparam int PRICE_IN_W  = 32;
  localparam int PERIOD_W    = 7;
  localparam int QTY_W       = 32;
  localparam int COUNT_W     = 32;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [PERIOD_W-1:0] RESET_FAST_PERIOD = PERIOD_W'(10);
  localparam logic [PERIOD_W-1:0] RESET_SLOW_PERIOD = PERIOD_W'(20);
  localparam logic [QTY_W-1:0]    RESET_ORDER_SIZE  = QTY_W'(1);

  // order queue depth; must be a power of two
  localparam int ORDER_Q_DEPTH = 4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENABLE,
    REG_FAST_PERIOD,
    REG_SLOW_PERIOD,
    REG_ORDER_SIZE
  } cfg_reg_t;

  typedef enum logic {
    SIDE_BUY  = 1'b0,
    SIDE_SELL = 1'b1
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [QTY_W-1:0]    quantity;
    logic [COUNT_W-1:0]  trade_count;
    logic                last;
  } order_t;

  // up to two orders pushed by one price
  typedef struct packed {
    logic [1:0] count;
    order_t     first;
    order_t     second;
  } order_push_t;

  typedef struct packed {
    logic not_empty;
    logic room_for_two;
  } q_status_t;

endpackage

FILE: hdl/scx_if.sv
// Channel interfaces of the crossover signal unit: price input, order output
// and configuration write port. Depends on scx_pkg.
interface scx_price_if import scx_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_IN_W-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface scx_order_if import scx_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               side;
  logic [QTY_W-1:0]   quantity;
  logic [COUNT_W-1:0] trade_count;
  logic               last;

  modport source (output valid, output side, output quantity, output trade_count,
                  output last, input ready);
  modport sink   (input valid, input side, input quantity, input trade_count,
                  input last, output ready);
endinterface

interface scx_cfg_if import scx_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: hdl/sma_crossover_signal_unit.sv
// Top level of the moving-average crossover signal unit.
// Depends on scx_pkg, the channel interfaces in scx_if and scx_order_fifo.
//
// Usage:
//   in_ch  : one trade price per item. While enable is zero, items are taken and
//            dropped without touching the window state.
//   out_ch : market orders (side, quantity, trade_count, last); a price that
//            crosses gives one or two orders, the final one flagged last.
//   cfg_ch : register writes (enable, fast and slow periods, order quantity),
//            always ready; write only while the unit is idle.
// Throughput: one price per cycle while the order queue does not stall the
//   pipeline. Each price reads the two departing entries of a ring of running
//   cumulative sums through two read ports and writes the new cumulative sum
//   back at the same edge, so the next price sees it without forwarding.
// Path: a price's ring reads are registered, its window sums are subtracted
//   and registered, the cross products multiplied and registered, then
//   compared; the orders go into the queue, a second one after the first.
// Reset (rst_n low, synchronous): window fill, sums, position flags and trade
//   counter clear; registers return to enable 0, periods 10 and 20, size 1.
//   The ring needs no clearing pass.
// Stall: orders go into a four-entry queue; when it cannot take two more, the
//   pipeline holds and in_ch.ready drops until the receiver drains it.
module sma_crossover_signal_unit import scx_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  scx_price_if.sink    in_ch,
  scx_order_if.source  out_ch,
  scx_cfg_if.sink      cfg_ch
);

  localparam int AW     = $clog2(MAX_WINDOW);      // ring address
  localparam int PW     = $clog2(MAX_WINDOW + 1);  // period 1..MAX_WINDOW
  localparam int HW     = $clog2(MAX_WINDOW + 2);  // history count, saturates at MAX+1
  localparam int SUM_W  = PRICE_BITS + AW;         // holds a full-window sum
  localparam int PROD_W = SUM_W + PW;

  // clamp a period into 1..MAX_WINDOW
  function automatic logic [PW-1:0] eff_period(input logic [PERIOD_W-1:0] p);
    logic [PW-1:0] r;
    if (p == '0) begin
      r = PW'(1);
    end else if (32'(p) > 32'(MAX_WINDOW)) begin
      r = PW'(MAX_WINDOW);
    end else begin
      r = PW'(p);
    end
    return r;
  endfunction

  // ring slot written n prices before the slot at wp
  function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] wp,
                                              input logic [PW-1:0] n);
    logic [AW+1:0] t;
    t = (AW+2)'(wp) + (AW+2)'(MAX_WINDOW) - (AW+2)'(n);
    if (t >= (AW+2)'(MAX_WINDOW)) begin
      t = t - (AW+2)'(MAX_WINDOW);
    end
    return t[AW-1:0];
  endfunction

  // configuration registers
  logic                enable_r;
  logic [PERIOD_W-1:0] fast_r;
  logic [PERIOD_W-1:0] slow_r;
  logic [QTY_W-1:0]    size_r;

  // window state
  logic [SUM_W-1:0] cum_mem [MAX_WINDOW];
  logic [SUM_W-1:0] cum_r;
  logic [AW-1:0]    wp_r;
  logic [PW-1:0]    fill_r;
  logic [HW-1:0]    hist_r;

  // decision state
  logic               was_above_r;
  logic               long_r;
  logic               short_r;
  logic [COUNT_W-1:0] cnt_r;

  // first stage: accept, update window, issue ring reads
  logic                             acc;
  logic                             advance;
  logic [PRICE_IN_W+PRICE_BITS-1:0] price_ext;
  logic [PRICE_BITS-1:0]            price_v;
  logic [PW-1:0]                    fp_a;
  logic [PW-1:0]                    sp_a;
  logic [SUM_W-1:0]                 cum_nxt;
  logic [AW-1:0]                    wp_nxt;
  logic [PW:0]                      fill_inc;
  logic [PW-1:0]                    fill_nxt;
  logic [HW-1:0]                    hist_nxt;
  logic                             full_a;
  logic [AW-1:0]                    addr_f;
  logic [AW-1:0]                    addr_s;

  logic             s1_v_r;
  logic [SUM_W-1:0] s1_cum_r;
  logic             s1_fzero_r;
  logic             s1_szero_r;
  logic             s1_fok_r;
  logic [PW-1:0]    s1_fp_r;
  logic [PW-1:0]    s1_sp_r;
  logic [SUM_W-1:0] rd_f_r;
  logic [SUM_W-1:0] rd_s_r;

  // second stage: window sums
  logic [SUM_W-1:0] fsum;
  logic [SUM_W-1:0] ssum;
  logic             s2_v_r;
  logic [SUM_W-1:0] s2_fsum_r;
  logic [SUM_W-1:0] s2_ssum_r;
  logic [PW-1:0]    s2_fp_r;
  logic [PW-1:0]    s2_sp_r;

  // third stage: cross products
  logic              s3_v_r;
  logic [PROD_W-1:0] s3_lhs_r;
  logic [PROD_W-1:0] s3_rhs_r;

  // decision
  logic        above;
  logic        fire;
  logic        buy;
  logic        sell;
  logic        two;
  side_t       side_d;
  order_push_t push;
  order_t      head;
  q_status_t   q_stat;
  logic        pop;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, unknown indices drop.
  // ---------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      fast_r   <= RESET_FAST_PERIOD;
      slow_r   <= RESET_SLOW_PERIOD;
      size_r   <= RESET_ORDER_SIZE;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.addr))
        REG_ENABLE:      enable_r <= cfg_ch.data[0];
        REG_FAST_PERIOD: fast_r   <= cfg_ch.data[PERIOD_W-1:0];
        REG_SLOW_PERIOD: slow_r   <= cfg_ch.data[PERIOD_W-1:0];
        REG_ORDER_SIZE:  size_r   <= cfg_ch.data[QTY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1. The ring holds the cumulative price sum after each price, so the
  // sum of the newest n prices is the new cumulative sum minus the entry
  // written n prices back. When n reaches back past the first price since
  // reset, the base is zero instead of a never-written entry.
  // ---------------------------------------------------------------------------
  assign advance     = !(s3_v_r && !q_stat.room_for_two);
  assign in_ch.ready = advance;
  assign acc         = in_ch.valid && advance && enable_r;

  assign price_ext = {{PRICE_BITS{1'b0}}, in_ch.price};
  assign price_v   = price_ext[PRICE_BITS-1:0];
  assign fp_a      = eff_period(fast_r);
  assign sp_a      = eff_period(slow_r);
  assign cum_nxt   = cum_r + SUM_W'(price_v);
  assign wp_nxt    = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + AW'(1);
  assign fill_inc  = (PW+1)'(fill_r) + (PW+1)'(1);
  assign fill_nxt  = (fill_inc > (PW+1)'(sp_a)) ? sp_a : fill_inc[PW-1:0];
  assign hist_nxt  = (hist_r == HW'(MAX_WINDOW + 1)) ? hist_r : hist_r + HW'(1);
  assign full_a    = (fill_nxt == sp_a);
  assign addr_f    = back_addr(wp_r, fp_a);
  assign addr_s    = back_addr(wp_r, sp_a);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cum_r  <= '0;
      wp_r   <= '0;
      fill_r <= '0;
      hist_r <= '0;
    end else if (acc) begin
      cum_r  <= cum_nxt;
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      hist_r <= hist_nxt;
    end
  end

  // read-first ring: a full-window read of the slot being written sees the
  // departing entry
  always_ff @(posedge clk) begin
    if (acc) begin
      cum_mem[wp_r] <= cum_nxt;
      rd_f_r        <= cum_mem[addr_f];
      rd_s_r        <= cum_mem[addr_s];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: subtract the bases. A fast period above the slow one gives zero.
  // ---------------------------------------------------------------------------
  assign fsum = s1_fok_r ? (s1_cum_r - (s1_fzero_r ? '0 : rd_f_r)) : '0;
  assign ssum = s1_cum_r - (s1_szero_r ? '0 : rd_s_r);

  // pipeline valids; only full-window prices travel down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= acc && full_a;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cum_r   <= cum_nxt;
      s1_fzero_r <= !(32'(fp_a) < 32'(hist_nxt));
      s1_szero_r <= !(32'(sp_a) < 32'(hist_nxt));
      s1_fok_r   <= (fp_a <= sp_a);
      s1_fp_r    <= fp_a;
      s1_sp_r    <= sp_a;
      s2_fsum_r  <= fsum;
      s2_ssum_r  <= ssum;
      s2_fp_r    <= s1_fp_r;
      s2_sp_r    <= s1_sp_r;
      // Stage 3: compare averages exactly by cross-multiplying
      s3_lhs_r   <= PROD_W'(s2_fsum_r) * PROD_W'(s2_sp_r);
      s3_rhs_r   <= PROD_W'(s2_ssum_r) * PROD_W'(s2_fp_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Decision: detect the cross, flip positions, push one or two orders.
  // ---------------------------------------------------------------------------
  assign above  = (s3_lhs_r > s3_rhs_r);
  assign fire   = s3_v_r && advance;
  assign buy    = above && !was_above_r && !long_r;
  assign sell   = !above && was_above_r && !short_r;
  assign two    = (buy && short_r) || (sell && long_r);
  assign side_d = buy ? SIDE_BUY : SIDE_SELL;

  always_comb begin
    push.count              = 2'd0;
    if (fire && (buy || sell)) begin
      push.count = two ? 2'd2 : 2'd1;
    end
    push.first.side         = side_d;
    push.first.quantity     = size_r;
    push.first.trade_count  = cnt_r + COUNT_W'(1);
    push.first.last         = !two;
    push.second.side        = side_d;
    push.second.quantity    = size_r;
    push.second.trade_count = cnt_r + COUNT_W'(2);
    push.second.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_above_r <= 1'b0;
      long_r      <= 1'b0;
      short_r     <= 1'b0;
      cnt_r       <= '0;
    end else if (fire) begin
      was_above_r <= above;
      cnt_r       <= cnt_r + COUNT_W'(push.count);
      if (buy) begin
        long_r  <= 1'b1;
        short_r <= 1'b0;
      end else if (sell) begin
        long_r  <= 1'b0;
        short_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Order queue and output channel.
  // ---------------------------------------------------------------------------
  scx_order_fifo u_order_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (q_stat)
  );

  assign pop                = out_ch.valid && out_ch.ready;
  assign out_ch.valid       = q_stat.not_empty;
  assign out_ch.side        = logic'(head.side);
  assign out_ch.quantity    = head.quantity;
  assign out_ch.trade_count = head.trade_count;
  assign out_ch.last        = head.last;

`ifndef ASSERT_OFF
  a_one_position: assert property (@(posedge clk) disable iff (!rst_n)
    !(long_r && short_r))
    else $error("long and short held at once");

  a_counter_moves_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !fire) |=> $stable(cnt_r))
    else $error("trade counter moved without a decision");

  a_disabled_keeps_window: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_ch.valid && in_ch.ready && !enable_r) |=>
      ($stable(cum_r) && $stable(wp_r) && $stable(fill_r)))
    else $error("disabled price changed the window");

  a_no_phantom_item: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && advance && !acc) |=> !s1_v_r)
    else $error("pipeline item without an accepted price");
`endif

endmodule

FILE: hdl/scx_order_fifo.sv
// Small order queue between the crossover decision stage and the output channel.
// Takes up to two orders per cycle, hands out one. Depends on scx_pkg.
module scx_order_fifo import scx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  order_push_t push,
  input  logic        pop,
  output order_t      head,
  output q_status_t   status
);

  localparam int QAW = $clog2(ORDER_Q_DEPTH);
  localparam int CW  = $clog2(ORDER_Q_DEPTH + 1);

  order_t          q_mem [ORDER_Q_DEPTH];
  logic [QAW-1:0]  wr_ptr_r;
  logic [QAW-1:0]  rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;

  assign count_nxt = count_r + CW'(push.count) - CW'(pop);

  // pointers wrap on their own since the depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QAW'(push.count);
      rd_ptr_r <= rd_ptr_r + QAW'(pop);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      q_mem[wr_ptr_r + QAW'(1)] <= push.second;
    end
  end

  assign head                = q_mem[rd_ptr_r];
  assign status.not_empty    = (count_r != '0);
  assign status.room_for_two = (count_r <= CW'(ORDER_Q_DEPTH - 2));

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ORDER_Q_DEPTH))
    else $error("order queue count above depth");

  a_pair_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count == 2'd2) |-> (count_r <= CW'(ORDER_Q_DEPTH - 2)))
    else $error("order pair pushed without room");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count == 2'd1) |-> push.first.last)
    else $error("single order not marked last");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count == 2'd2) |-> (!push.first.last && push.second.last &&
      (push.second.trade_count == push.first.trade_count + COUNT_W'(1))))
    else $error("order pair malformed");
`endif

endmodule
